// ===== rtl/htlp_pkg.sv =====
// Package for the linear-probe hash table: widths, result codes and controller/datapath links.
package htlp_pkg;

	localparam int TABLE_SLOTS_DEF = 64;
	localparam int NAME_BYTES_DEF  = 16;
	localparam int CHAR_W          = 8;
	localparam int ICON_W          = 16;
	localparam int STATUS_W        = 2;
	localparam int SLOT_OUT_W      = 6;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic    clr_step;
		logic    take;
		logic    probe_init;
		logic    meta_rd;
		logic    meta_wr;
		logic    idx_next;
		logic    byte_rst;
		logic    cmp_rd;
		logic    copy_rd;
		logic    copy_wr;
		logic    res_load;
		logic    collect_clr;
		status_t res_code;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hash_busy;
		logic op_search;
		logic meta_valid;
		logic len_eq;
		logic wrap;
		logic bytes_done;
		logic byte_eq;
	} dp_sts_t;

endpackage

// ===== rtl/htlp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module htlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/htlp_ctrl.sv =====
// Sequencing state machine for the clearing pass, name collection, probing, key compare, key copy and result handoff.
module htlp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_char,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  htlp_pkg::dp_sts_t sts,
	output htlp_pkg::dp_cmd_t cmd
);
	import htlp_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b00_0000_0001,
		S_COLLECT  = 10'b00_0000_0010,
		S_PRB_INIT = 10'b00_0000_0100,
		S_PRB_RD   = 10'b00_0000_1000,
		S_PRB_CHK  = 10'b00_0001_0000,
		S_CMP_RD   = 10'b00_0010_0000,
		S_CMP_CHK  = 10'b00_0100_0000,
		S_CPY_RD   = 10'b00_1000_0000,
		S_CPY_WR   = 10'b01_0000_0000,
		S_DONE     = 10'b10_0000_0000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    out_valid_q;

	assign in_stall  = (state_q != S_COLLECT) || sts.hash_busy;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		code_d   = code_q;
		cmd.res_code = code_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_COLLECT;
				end
			end
			S_COLLECT: begin
				if (in_valid && !in_stall) begin
					cmd.take = 1'b1;
					if (last_char) begin
						state_d = S_PRB_INIT;
					end
				end
			end
			S_PRB_INIT: begin
				if (!sts.hash_busy) begin
					cmd.probe_init = 1'b1;
					state_d        = S_PRB_RD;
				end
			end
			S_PRB_RD: begin
				cmd.meta_rd = 1'b1;
				state_d     = S_PRB_CHK;
			end
			S_PRB_CHK: begin
				if (!sts.op_search) begin
					if (!sts.meta_valid) begin
						cmd.meta_wr  = 1'b1;
						cmd.byte_rst = 1'b1;
						state_d      = S_CPY_RD;
					end else if (sts.wrap) begin
						code_d  = ST_FULL;
						state_d = S_DONE;
					end else begin
						cmd.idx_next = 1'b1;
						state_d      = S_PRB_RD;
					end
				end else begin
					if (!sts.meta_valid) begin
						code_d  = ST_NOT_FOUND;
						state_d = S_DONE;
					end else if (sts.len_eq) begin
						cmd.byte_rst = 1'b1;
						state_d      = S_CMP_RD;
					end else if (sts.wrap) begin
						code_d  = ST_NOT_FOUND;
						state_d = S_DONE;
					end else begin
						cmd.idx_next = 1'b1;
						state_d      = S_PRB_RD;
					end
				end
			end
			S_CMP_RD: begin
				if (sts.bytes_done) begin
					code_d  = ST_FOUND;
					state_d = S_DONE;
				end else begin
					cmd.cmp_rd = 1'b1;
					state_d    = S_CMP_CHK;
				end
			end
			S_CMP_CHK: begin
				if (sts.byte_eq) begin
					state_d = S_CMP_RD;
				end else if (sts.wrap) begin
					code_d  = ST_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					cmd.idx_next = 1'b1;
					state_d      = S_PRB_RD;
				end
			end
			S_CPY_RD: begin
				if (sts.bytes_done) begin
					code_d  = ST_INSERTED;
					state_d = S_DONE;
				end else begin
					cmd.copy_rd = 1'b1;
					state_d     = S_CPY_WR;
				end
			end
			S_CPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d     = S_CPY_RD;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.res_load    = 1'b1;
					cmd.collect_clr = 1'b1;
					state_d         = S_COLLECT;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			code_q      <= ST_INSERTED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/htlp_dp.sv =====
// Datapath: name collector, hash and remainder unit, probe index, table RAMs and result register.
module htlp_dp #(
	parameter int TABLE_SLOTS = htlp_pkg::TABLE_SLOTS_DEF,
	parameter int NAME_BYTES  = htlp_pkg::NAME_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  htlp_pkg::dp_cmd_t                    cmd,
	output htlp_pkg::dp_sts_t                    sts,
	input  logic                                 opcode,
	input  logic [htlp_pkg::CHAR_W-1:0]          name_char,
	input  logic                                 last_char,
	input  logic [htlp_pkg::ICON_W-1:0]          icon_code,
	output logic [htlp_pkg::STATUS_W-1:0]        status,
	output logic [htlp_pkg::ICON_W-1:0]          found_icon,
	output logic [htlp_pkg::SLOT_OUT_W-1:0]      slot
);
	import htlp_pkg::*;

	localparam int SW      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int NB_W    = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
	localparam int CNT_W   = $clog2(NAME_BYTES + 1);
	localparam int KEY_D   = TABLE_SLOTS * NAME_BYTES;
	localparam int KA_W    = (KEY_D > 1) ? $clog2(KEY_D) : 1;
	localparam int META_W  = 1 + CNT_W + ICON_W;
	localparam int PW      = $clog2((TABLE_SLOTS + 255) * 255);
	localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

	// Name collector.
	logic [CNT_W-1:0]  count_q;
	logic              ended_q;
	logic              op_q;
	logic [ICON_W-1:0] icon_q;
	logic [SW-1:0]     h_q;
	logic              store_byte;
	logic [PW-1:0]     prod;

	assign store_byte = cmd.take && !ended_q && (name_char != '0) &&
		(count_q < CNT_W'(NAME_BYTES));
	assign prod = (PW'(h_q) + PW'(name_char)) * PW'(name_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ended_q <= 1'b0;
		end else if (cmd.collect_clr) begin
			count_q <= '0;
			ended_q <= 1'b0;
		end else if (cmd.take && !ended_q) begin
			if (store_byte) begin
				count_q <= count_q + 1'b1;
				if (count_q + 1'b1 >= CNT_W'(NAME_BYTES)) begin
					ended_q <= 1'b1;
				end
			end else begin
				ended_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && last_char) begin
			op_q   <= opcode;
			icon_q <= icon_code;
		end
	end

	// Hash: a mask for a power-of-two table, otherwise a reciprocal remainder that holds the hash busy until done.
	generate
		if (IS_POW2) begin : g_pow2
			assign sts.hash_busy = 1'b0;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					h_q <= '0;
				end else if (cmd.collect_clr) begin
					h_q <= '0;
				end else if (store_byte) begin
					h_q <= prod[SW-1:0];
				end
			end
		end else begin : g_mod
			// The quotient is the product times a rounded-up reciprocal, shifted down; with
			// this shift it is exact for every product that the hash can form.
			localparam int KSH = PW + SW;
			localparam int RW  = PW + 1;
			localparam longint unsigned RECIP =
				((64'd1 << KSH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
			logic [PW-1:0]    p_q, q_q, qt;
			logic [PW+RW-1:0] qprod;
			logic             busy_q, phase_q;

			assign qprod = (PW+RW)'(p_q) * (PW+RW)'(RW'(RECIP));
			assign qt    = q_q * PW'(TABLE_SLOTS);

			assign sts.hash_busy = busy_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					h_q     <= '0;
					busy_q  <= 1'b0;
					phase_q <= 1'b0;
				end else if (cmd.collect_clr) begin
					h_q     <= '0;
					busy_q  <= 1'b0;
					phase_q <= 1'b0;
				end else if (store_byte) begin
					busy_q  <= 1'b1;
					phase_q <= 1'b0;
				end else if (busy_q) begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						h_q     <= SW'(p_q - qt);
						busy_q  <= 1'b0;
						phase_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (store_byte) begin
					p_q <= prod;
				end
				if (busy_q && !phase_q) begin
					q_q <= PW'(qprod >> KSH);
				end
			end
		end
	endgenerate

	// Probe index, clear sweep and byte index.
	logic [SW-1:0]    idx_q, start_q, clr_q, idx_inc;
	logic [CNT_W-1:0] bi_q;

	assign idx_inc = (idx_q == SW'(TABLE_SLOTS - 1)) ? '0 : idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_init) begin
			idx_q   <= h_q;
			start_q <= h_q;
		end else if (cmd.idx_next) begin
			idx_q <= idx_inc;
		end
		if (cmd.byte_rst) begin
			bi_q <= '0;
		end else if (cmd.cmp_rd || cmd.copy_wr) begin
			bi_q <= bi_q + 1'b1;
		end
	end

	// Slot records: valid, key length, icon.
	logic              meta_we;
	logic [SW-1:0]     meta_wa;
	logic [META_W-1:0] meta_wd, meta_rd;

	assign meta_we = cmd.clr_step || cmd.meta_wr;
	assign meta_wa = cmd.clr_step ? clr_q : idx_q;
	assign meta_wd = cmd.clr_step ? '0 : {1'b1, count_q, icon_q};

	htlp_ram #(.WIDTH(META_W), .DEPTH(TABLE_SLOTS)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_wa),
		.wdata (meta_wd),
		.re    (cmd.meta_rd),
		.raddr (idx_q),
		.rdata (meta_rd)
	);

	// Name buffer and stored key bytes.
	logic [CHAR_W-1:0] nb_rd, key_rd;
	logic [KA_W-1:0]   key_addr;

	assign key_addr = KA_W'(idx_q) * KA_W'(NAME_BYTES) + KA_W'(bi_q);

	htlp_ram #(.WIDTH(CHAR_W), .DEPTH(NAME_BYTES)) u_name (
		.clk   (clk),
		.we    (store_byte),
		.waddr (count_q[NB_W-1:0]),
		.wdata (name_char),
		.re    (cmd.cmp_rd || cmd.copy_rd),
		.raddr (bi_q[NB_W-1:0]),
		.rdata (nb_rd)
	);

	htlp_ram #(.WIDTH(CHAR_W), .DEPTH(KEY_D)) u_key (
		.clk   (clk),
		.we    (cmd.copy_wr),
		.waddr (key_addr),
		.wdata (nb_rd),
		.re    (cmd.cmp_rd),
		.raddr (key_addr),
		.rdata (key_rd)
	);

	assign sts.clr_done   = clr_q == SW'(TABLE_SLOTS - 1);
	assign sts.op_search  = op_q;
	assign sts.meta_valid = meta_rd[META_W-1];
	assign sts.len_eq     = meta_rd[META_W-2 -: CNT_W] == count_q;
	assign sts.wrap       = idx_inc == start_q;
	assign sts.bytes_done = bi_q == count_q;
	assign sts.byte_eq    = nb_rd == key_rd;

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status     <= cmd.res_code;
			found_icon <= (cmd.res_code == ST_FOUND) ? meta_rd[ICON_W-1:0] : '0;
			slot       <= (cmd.res_code == ST_FOUND || cmd.res_code == ST_INSERTED) ?
				SLOT_OUT_W'(idx_q) : '0;
		end
	end
endmodule

// ===== rtl/hash_table_linear_probe_unit.sv =====
// Top level of the open-addressing hash table with linear probing over byte names.
// Name bytes are taken one item per cycle for a power-of-two table; otherwise each hashed byte
// stalls input while the reciprocal remainder unit reduces it.
// After the last byte the probe index loads from the hash; each slot record is read, then checked,
// each key byte is compared or copied, a last check ends the match or copy, then the result loads.
// After reset a clearing pass writes every slot record, with input stalled.
module hash_table_linear_probe_unit #(
	parameter int TABLE_SLOTS = htlp_pkg::TABLE_SLOTS_DEF,
	parameter int NAME_BYTES  = htlp_pkg::NAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [htlp_pkg::CHAR_W-1:0]     name_char,
	input  logic                            last_char,
	input  logic [htlp_pkg::ICON_W-1:0]     icon_code,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [htlp_pkg::STATUS_W-1:0]   status,
	output logic [htlp_pkg::ICON_W-1:0]     found_icon,
	output logic [htlp_pkg::SLOT_OUT_W-1:0] slot
);
	import htlp_pkg::*;

	// The controller issues commands and watches status; tables and names live in the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	htlp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_char (last_char),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The result register sits in the datapath, so a finished item can wait on the output
	// while the next name is already being collected.
	htlp_dp #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.NAME_BYTES  (NAME_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.name_char  (name_char),
		.last_char  (last_char),
		.icon_code  (icon_code),
		.status     (status),
		.found_icon (found_icon),
		.slot       (slot)
	);

	// A result only appears after the block has stopped taking input to probe.
	a_out_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a probe phase");

	// The item that ends a name always starts a probe, which stalls the input.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_char) |=> in_stall)
		else $error("input not stalled after the last byte of a name");

	// Misses and full-table results carry no slot and no icon.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL || status == ST_NOT_FOUND)) |->
		(slot == '0 && found_icon == '0))
		else $error("miss result carries a slot or icon");
endmodule
